// ===== rtl/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-class priority queue package
// Shared types, codes and constants for the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_QUEUES      = 3;
    localparam int AGE_W           = 7;
    localparam int TAG_W           = 16;
    localparam int CONTACT_W       = 40;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [AGE_W-1:0] ELDER_AGE_MIN_RST = 7'd75;
    localparam logic [AGE_W-1:0] CHILD_AGE_MAX_RST = 7'd4;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ELDER_AGE_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHILD_AGE_MAX = 1'b1;

    // Operation codes.
    localparam logic [1:0] OP_ADMIT  = 2'd0;
    localparam logic [1:0] OP_SERVE  = 2'd1;
    localparam logic [1:0] OP_URGENT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_ADMITTED = 2'd0;
    localparam logic [1:0] STATUS_SERVED   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    // Queue classes.
    localparam logic [1:0] CLASS_HIGH   = 2'd0;
    localparam logic [1:0] CLASS_CHILD  = 2'd1;
    localparam logic [1:0] CLASS_NORMAL = 2'd2;

    typedef struct packed {
        logic [1:0]           operation;
        logic [AGE_W-1:0]     age_value;
        logic [TAG_W-1:0]     record_tag;
        logic [CONTACT_W-1:0] contact_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           served_class;
        logic [AGE_W-1:0]     out_age;
        logic [TAG_W-1:0]     out_tag;
        logic [CONTACT_W-1:0] out_contact;
    } out_item_t;

    typedef struct packed {
        logic [AGE_W-1:0]     age;
        logic [TAG_W-1:0]     tag;
        logic [CONTACT_W-1:0] contact;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;     // capture the accepted input transaction
        logic do_exec;       // update pointers and counts, write or read the store
        logic out_load_exec; // load a result that needs no store read
        logic out_load_read; // load a served record from the store read data
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_nop;
        logic serve_hit;
        logic out_free;
    } dpath_status_t;

endpackage

// ===== rtl/tcpq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Three-class priority queue controller
// Sequences each transaction through capture, execute and, for a successful serve, store read.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  tcpq_pkg::dpath_status_t stat,
    output tcpq_pkg::ctrl_cmd_t    cmd
);

    import tcpq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_nop)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.serve_hit)
                begin
                    // The store read is issued now; the result is loaded in ST_READ once the result register is free.
                    cmd.do_exec = 1'b1;
                    state_next  = ST_READ;
                end
                else if (stat.out_free)
                begin
                    cmd.do_exec       = 1'b1;
                    cmd.out_load_exec = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load_read = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/tcpq_dpath.sv =====
// ----------------------------------------------------------------------------
// Three-class priority queue datapath
// Thresholds, circular-buffer pointers, record stores and the result register.
// ----------------------------------------------------------------------------
module tcpq_dpath #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [tcpq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcpq_pkg::AGE_W-1:0]          cfg_data,
    input  tcpq_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tcpq_pkg::out_item_t                 result,
    input  tcpq_pkg::ctrl_cmd_t                 cmd,
    output tcpq_pkg::dpath_status_t             stat
);

    import tcpq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    logic [AGE_W-1:0] elder_age_min_reg;
    logic [AGE_W-1:0] child_age_max_reg;

    in_item_t item_reg;

    logic [PTR_W-1:0] head_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [CNT_W-1:0] count_reg [NUM_QUEUES];
    logic [CNT_W-1:0] count_next[NUM_QUEUES];

    logic [PTR_W-1:0] tail_slot [NUM_QUEUES];
    logic [PTR_W-1:0] prev_slot [NUM_QUEUES];
    logic [PTR_W-1:0] succ_slot [NUM_QUEUES];
    logic [PTR_W:0]   tail_sum  [NUM_QUEUES];
    logic [REC_W-1:0] rd_data   [NUM_QUEUES];

    logic [NUM_QUEUES-1:0] nonempty;
    logic [NUM_QUEUES-1:0] full_q;
    logic [NUM_QUEUES-1:0] adm_sel;
    logic [NUM_QUEUES-1:0] srv_sel;
    logic [NUM_QUEUES-1:0] wr_en;
    logic [NUM_QUEUES-1:0] rd_en;

    logic       is_serve;
    logic       is_urgent;
    logic       is_admit;
    logic [1:0] adm_q;
    logic [1:0] srv_q;
    logic       adm_full;
    logic [1:0] srv_q_reg;
    rec_t       wr_rec;
    rec_t       served_rec;

    out_item_t exec_result;
    out_item_t result_reg;
    logic      result_valid_reg;
    logic      out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elder_age_min_reg <= ELDER_AGE_MIN_RST;
            child_age_max_reg <= CHILD_AGE_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ELDER_AGE_MIN: elder_age_min_reg <= cfg_data;
                REG_CHILD_AGE_MAX: child_age_max_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
    end

    // Decode of the captured transaction.
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
            full_q[i]   = (count_reg[i] == DEPTH_CNT);
        end

        is_serve  = (item_reg.operation == OP_SERVE);
        is_urgent = (item_reg.operation == OP_URGENT);
        is_admit  = (item_reg.operation == OP_ADMIT) || is_urgent;

        if (is_urgent || (item_reg.age_value >= elder_age_min_reg))
        begin
            adm_q = CLASS_HIGH;
        end
        else if (item_reg.age_value <= child_age_max_reg)
        begin
            adm_q = CLASS_CHILD;
        end
        else
        begin
            adm_q = CLASS_NORMAL;
        end

        adm_sel = '0;
        case (adm_q)
            CLASS_HIGH:   adm_sel[0] = 1'b1;
            CLASS_CHILD:  adm_sel[1] = 1'b1;
            default:      adm_sel[2] = 1'b1;
        endcase

        // Strict priority: the lowest-numbered nonempty queue wins.
        srv_sel[0] = nonempty[0];
        srv_sel[1] = !nonempty[0] && nonempty[1];
        srv_sel[2] = !nonempty[0] && !nonempty[1] && nonempty[2];
        if (srv_sel[0])
        begin
            srv_q = CLASS_HIGH;
        end
        else if (srv_sel[1])
        begin
            srv_q = CLASS_CHILD;
        end
        else
        begin
            srv_q = CLASS_NORMAL;
        end

        adm_full = |(adm_sel & full_q);
    end

    // Per-queue pointer arithmetic. The tail sum stays below twice the depth,
    // so one compare and subtract wraps it.
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            tail_sum[i]  = {1'b0, head_reg[i]} + {1'b0, count_reg[i][PTR_W-1:0]};
            tail_slot[i] = (tail_sum[i] >= DEPTH_EXT) ? PTR_W'(tail_sum[i] - DEPTH_EXT)
                                                      : tail_sum[i][PTR_W-1:0];
            prev_slot[i] = (head_reg[i] == '0) ? LAST_SLOT : head_reg[i] - PTR_W'(1);
            succ_slot[i] = (head_reg[i] == LAST_SLOT) ? '0 : head_reg[i] + PTR_W'(1);

            wr_en[i] = cmd.do_exec && is_admit && adm_sel[i] && !full_q[i];
            rd_en[i] = cmd.do_exec && is_serve && srv_sel[i];

            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
            if (wr_en[i])
            begin
                count_next[i] = count_reg[i] + CNT_W'(1);
                if (is_urgent)
                begin
                    head_next[i] = prev_slot[i];
                end
            end
            else if (rd_en[i])
            begin
                count_next[i] = count_reg[i] - CNT_W'(1);
                head_next[i]  = succ_slot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_exec && is_serve)
        begin
            srv_q_reg <= srv_q;
        end
    end

    assign wr_rec.age     = item_reg.age_value;
    assign wr_rec.tag     = item_reg.record_tag;
    assign wr_rec.contact = item_reg.contact_value;

    for (genvar g = 0; g < NUM_QUEUES; g++)
    begin : g_store
        tcpq_ram #(
            .WIDTH (REC_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[g]),
            .wr_addr (is_urgent ? prev_slot[g] : tail_slot[g]),
            .wr_data (wr_rec),
            .rd_en   (rd_en[g]),
            .rd_addr (head_reg[g]),
            .rd_data (rd_data[g])
        );
    end

    always_comb
    begin
        case (srv_q_reg)
            CLASS_HIGH:  served_rec = rd_data[0];
            CLASS_CHILD: served_rec = rd_data[1];
            default:     served_rec = rd_data[2];
        endcase

        exec_result = '0;
        if (is_serve)
        begin
            exec_result.status       = STATUS_EMPTY;
            exec_result.served_class = CLASS_HIGH;
        end
        else
        begin
            exec_result.status       = adm_full ? STATUS_FULL : STATUS_ADMITTED;
            exec_result.served_class = adm_q;
        end
    end

    // Result register: holds a finished result while the consumer stalls.
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_exec || cmd.out_load_read)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_exec)
        begin
            result_reg <= exec_result;
        end
        else if (cmd.out_load_read)
        begin
            result_reg.status       <= STATUS_SERVED;
            result_reg.served_class <= srv_q_reg;
            result_reg.out_age      <= served_rec.age;
            result_reg.out_tag      <= served_rec.tag;
            result_reg.out_contact  <= served_rec.contact;
        end
    end

    assign result_valid   = result_valid_reg;
    assign result         = result_reg;
    assign stat.is_nop    = (item_reg.operation == OP_NONE);
    assign stat.serve_hit = is_serve && (|nonempty);
    assign stat.out_free  = out_free;

endmodule

// ===== rtl/three_class_priority_queue.sv =====
// Sequence: each transaction is captured, then executed. An admit or an empty serve
// loads its result when executed, a successful serve from the store read in ST_READ;
// a load waits while the result is stalled. An ignored operation ends with no result.
// A new transaction is taken only once the last is done (item_stall is raised meanwhile).
// Reset (rst_n, asynchronous) clears pointers, counts and the result valid, restores
// the thresholds to 75 and 4, and leaves the record stores unwritten.
// ----------------------------------------------------------------------------
// Three-class priority queue
// Strict-priority record queue: three circular FIFO classes, urgent admits at the head.
// ----------------------------------------------------------------------------
module three_class_priority_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  tcpq_pkg::in_item_t               item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output tcpq_pkg::out_item_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcpq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcpq_pkg::AGE_W-1:0]       cfg_data
);

    import tcpq_pkg::*;

    ctrl_cmd_t     cmd;
    dpath_status_t stat;

    assign cfg_ready = 1'b1;

    tcpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tcpq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== rtl/tcpq_checker.sv =====
// ----------------------------------------------------------------------------
// Three-class priority queue checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tcpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input tcpq_pkg::out_item_t result
);

    import tcpq_pkg::*;

    // A stalled result stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // One transaction at a time: input is stalled right after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input accepted while a transaction is in work");

    // Only a served record carries payload.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STATUS_SERVED) |->
            (result.out_age == '0) && (result.out_tag == '0) && (result.out_contact == '0))
        else $error("payload set on a result that serves no record");

    // An empty serve reports the high class.
    a_empty_class: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_EMPTY) |-> result.served_class == CLASS_HIGH)
        else $error("empty result with nonzero class");

endmodule

bind three_class_priority_queue tcpq_checker u_tcpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
